[design/bpa_pkg.sv]
// Shared types and constants for the buddy page allocator.
// No dependencies; imported by the top level and the page memory.
package bpa_pkg;

    localparam int ORDER_W = 4;
    localparam int TOTAL_W = 13;
    localparam int POW_W   = 17;
    localparam int META_W  = 1 + ORDER_W;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'd8191;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_NO_BLOCK = 2'd1;
    localparam logic [1:0] STATUS_BAD_ORD  = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_ALLOC,
        ST_SPLIT,
        ST_FREE_RD,
        ST_FREE_EV,
        ST_MERGE_RD,
        ST_MERGE_EV,
        ST_FREE_INS,
        ST_INS_RD,
        ST_INS_EV,
        ST_INS_LINK,
        ST_INS_PREV,
        ST_UNL_RD,
        ST_UNL_WR,
        ST_FINISH
    } state_t;

endpackage

[design/bpa_page_mem.sv]
// Per-page storage: free mark and order, next link and previous link.
// Three simple dual-port memories with registered reads; uses bpa_pkg.
module bpa_page_mem #(
    parameter int NUM_PAGES = 4096,
    parameter int PAGE_W    = 12,
    parameter int LINK_W    = 13
) (
    input  logic                      aclk,
    input  logic [PAGE_W-1:0]         rd_addr,
    input  logic                      meta_we,
    input  logic [PAGE_W-1:0]         meta_waddr,
    input  logic [bpa_pkg::META_W-1:0] meta_wdata,
    input  logic                      next_we,
    input  logic [PAGE_W-1:0]         next_waddr,
    input  logic [LINK_W-1:0]         next_wdata,
    input  logic                      prev_we,
    input  logic [PAGE_W-1:0]         prev_waddr,
    input  logic [LINK_W-1:0]         prev_wdata,
    output logic [bpa_pkg::META_W-1:0] meta_rdata,
    output logic [LINK_W-1:0]         next_rdata,
    output logic [LINK_W-1:0]         prev_rdata
);
    import bpa_pkg::*;

    logic [META_W-1:0] meta_mem [NUM_PAGES];
    logic [LINK_W-1:0] next_mem [NUM_PAGES];
    logic [LINK_W-1:0] prev_mem [NUM_PAGES];

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rdata <= meta_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rdata <= next_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rdata <= prev_mem[rd_addr];
    end

endmodule

[design/buddy_page_allocator.sv]
// Buddy page allocator top level: request sequencer, free-list heads and totals.
// Depends on bpa_pkg and bpa_page_mem.
//
// This block manages NUM_PAGES pages as power-of-two blocks of up to
// 2^(ORDER_COUNT-1) pages. Each request transfer carries a mode in s_tuser:
// add a free region, allocate a block of a given order, or free a block. Each
// request yields exactly one result transfer with a status in m_tuser and the
// allocated block start and the current free-page total in m_tdata. After
// reset the block runs a clearing pass over its page memory, during which
// s_tready stays low. Requests are handled one at a time by a sequencer
// around the page memory, whose registered reads set the pace. Filing a block
// reads its first page, takes it off its old list when it is already free,
// links it in front of its list head and then points the old head back at it;
// taking a block off a list reads its links, rejoins its neighbours and clears
// its free mark. An add seeds, at each position in its region, the largest
// aligned block that fits and files it; an alloc takes the head of the first
// non-empty list at or above the order, unlinks it and files the upper half
// at each split level; a free unlinks the block if it is still filed, merges
// it with its free buddy level by level and files the result. A finished
// result is held in an output register, so the next request is accepted while
// that result still waits to be taken.
module buddy_page_allocator #(
    parameter int NUM_PAGES   = 4096,
    parameter int ORDER_COUNT = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // page_number[11:0], region_end[24:12], block_order[28:25]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // block_start[11:0], free_total[24:12]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import bpa_pkg::*;

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int LW  = PW + 1;
    localparam int CW  = (PW + 1 > 13) ? PW + 1 : 13;
    localparam int EW  = ((CW > 16) ? CW : 16) + 1;
    localparam int OBW = $clog2(ORDER_COUNT);
    localparam logic [LW-1:0] NO_LINK = {LW{1'b1}};
    localparam logic [EW-1:0] PC_E    = EW'(NUM_PAGES);

    // Request fields.
    logic [1:0]  in_mode;
    logic [11:0] in_page;
    logic [12:0] in_end;
    logic [3:0]  in_order;
    assign in_mode  = s_tuser[1:0];
    assign in_page  = s_tdata[11:0];
    assign in_end   = s_tdata[24:12];
    assign in_order = s_tdata[28:25];

    // Sequencer state.
    state_t state_reg, state_next;
    state_t ins_ret_reg, ins_ret_next;
    state_t unl_ret_reg, unl_ret_next;
    logic [CW-1:0]      cur_reg, cur_next;
    logic [CW-1:0]      end_reg, end_next;
    logic [ORDER_W-1:0] ord_reg, ord_next;
    logic [ORDER_W-1:0] cur_ord_reg, cur_ord_next;
    logic [PW-1:0]      start_reg, start_next;
    logic [1:0]         status_reg, status_next;
    logic [PW-1:0]      ins_p_reg, ins_p_next;
    logic [ORDER_W-1:0] ins_o_reg, ins_o_next;
    logic [PW-1:0]      unl_p_reg, unl_p_next;
    logic [LW-1:0]      h_reg, h_next;
    logic [PW-1:0]      clr_reg, clr_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [LW-1:0]      head_reg [ORDER_COUNT];
    logic [LW-1:0]      head_next [ORDER_COUNT];

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [PW-1:0]      out_start_reg, out_start_next;
    logic [TOTAL_W-1:0] out_total_reg, out_total_next;

    // Page memory ports.
    logic [PW-1:0]      rd_addr;
    logic               meta_we, next_we, prev_we;
    logic [PW-1:0]      meta_waddr, next_waddr, prev_waddr;
    logic [META_W-1:0]  meta_wdata, meta_rdata;
    logic [LW-1:0]      next_wdata, prev_wdata, next_rdata, prev_rdata;

    bpa_page_mem #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_W     (PW),
        .LINK_W     (LW)
    ) u_mem (
        .aclk       (aclk),
        .rd_addr    (rd_addr),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .next_we    (next_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata),
        .prev_we    (prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .meta_rdata (meta_rdata),
        .next_rdata (next_rdata),
        .prev_rdata (prev_rdata)
    );

    // Largest aligned block that fits at the current add position.
    logic [ORDER_W-1:0] add_o;
    always_comb begin
        logic [EW-1:0] sz;
        add_o = '0;
        for (int o = 0; o < ORDER_COUNT; o++) begin
            sz = EW'(1) << o;
            if (((EW'(cur_reg) & (sz - EW'(1))) == '0) &&
                (EW'(cur_reg) + sz <= EW'(end_reg))) begin
                add_o = ORDER_W'(o);
            end
        end
    end

    // First non-empty free list at or above the requested order.
    logic               found;
    logic [ORDER_W-1:0] found_o;
    always_comb begin
        found   = 1'b0;
        found_o = '0;
        for (int o = ORDER_COUNT - 1; o >= 0; o--) begin
            if ((ORDER_W'(o) >= ord_reg) && (head_reg[o] != NO_LINK)) begin
                found   = 1'b1;
                found_o = ORDER_W'(o);
            end
        end
    end

    // Buddy of the block under merge.
    logic [EW-1:0] buddy;
    assign buddy = EW'(cur_reg) ^ (EW'(1) << cur_ord_reg);

    // Fields of the entry read for an unlink.
    logic [ORDER_W-1:0] u_ord;
    logic [OBW-1:0]     u_idx;
    assign u_ord = meta_rdata[ORDER_W-1:0];
    assign u_idx = (32'(u_ord) >= ORDER_COUNT) ? '0 : u_ord[OBW-1:0];

    logic [POW_W-1:0] u_pow, i_pow, add_sum;
    assign u_pow   = POW_W'(1) << u_idx;
    assign i_pow   = POW_W'(1) << ins_o_reg;
    assign add_sum = POW_W'(total_reg) + i_pow;

    logic [EW-1:0] split_p;
    assign split_p = EW'(start_reg) + (EW'(1) << (cur_ord_reg - ORDER_W'(1)));

    logic [EW-1:0] in_end_c;
    assign in_end_c = (EW'(in_end) > PC_E) ? PC_E : EW'(in_end);

    always_comb begin
        state_next      = state_reg;
        ins_ret_next    = ins_ret_reg;
        unl_ret_next    = unl_ret_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        ord_next        = ord_reg;
        cur_ord_next    = cur_ord_reg;
        start_next      = start_reg;
        status_next     = status_reg;
        ins_p_next      = ins_p_reg;
        ins_o_next      = ins_o_reg;
        unl_p_next      = unl_p_reg;
        h_next          = h_reg;
        clr_next        = clr_reg;
        total_next      = total_reg;
        head_next       = head_reg;
        m_valid_next    = m_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_total_next  = out_total_reg;
        rd_addr         = unl_p_reg;
        meta_we         = 1'b0;
        meta_waddr      = ins_p_reg;
        meta_wdata      = '0;
        next_we         = 1'b0;
        next_waddr      = ins_p_reg;
        next_wdata      = '0;
        prev_we         = 1'b0;
        prev_waddr      = ins_p_reg;
        prev_wdata      = '0;
        s_tready        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                if (clr_reg == PW'(NUM_PAGES - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + PW'(1);
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ord_next    = in_order;
                    status_next = STATUS_DONE;
                    start_next  = '0;
                    end_next    = CW'(in_end_c);
                    cur_next    = CW'(in_page);
                    unique case (in_mode)
                        MODE_ADD:   state_next = ST_ADD;
                        MODE_ALLOC: state_next = ST_ALLOC;
                        MODE_FREE: begin
                            cur_ord_next = in_order;
                            if (32'(in_order) >= ORDER_COUNT) begin
                                status_next = STATUS_BAD_ORD;
                                state_next  = ST_FINISH;
                            end else if (EW'(in_page) >= PC_E) begin
                                state_next = ST_FINISH;
                            end else begin
                                state_next = ST_FREE_RD;
                            end
                        end
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_ADD: begin
                if (cur_reg < end_reg) begin
                    ins_p_next   = PW'(cur_reg);
                    ins_o_next   = add_o;
                    cur_next     = CW'(EW'(cur_reg) + (EW'(1) << add_o));
                    ins_ret_next = ST_ADD;
                    state_next   = ST_INS_RD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_ALLOC: begin
                if (32'(ord_reg) >= ORDER_COUNT) begin
                    status_next = STATUS_BAD_ORD;
                    state_next  = ST_FINISH;
                end else if (POW_W'(total_reg) < (POW_W'(1) << ord_reg) || !found) begin
                    status_next = STATUS_NO_BLOCK;
                    state_next  = ST_FINISH;
                end else begin
                    start_next   = PW'(head_reg[found_o[OBW-1:0]]);
                    unl_p_next   = PW'(head_reg[found_o[OBW-1:0]]);
                    cur_ord_next = found_o;
                    unl_ret_next = ST_SPLIT;
                    state_next   = ST_UNL_RD;
                end
            end
            ST_SPLIT: begin
                // Walk down one order per visit and file the upper half.
                if (cur_ord_reg > ord_reg) begin
                    cur_ord_next = cur_ord_reg - ORDER_W'(1);
                    if (split_p < PC_E) begin
                        ins_p_next   = PW'(split_p);
                        ins_o_next   = cur_ord_reg - ORDER_W'(1);
                        ins_ret_next = ST_SPLIT;
                        state_next   = ST_INS_RD;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FREE_RD: begin
                rd_addr    = PW'(cur_reg);
                state_next = ST_FREE_EV;
            end
            ST_FREE_EV: begin
                if (meta_rdata[META_W-1]) begin
                    unl_p_next   = PW'(cur_reg);
                    unl_ret_next = ST_MERGE_RD;
                    state_next   = ST_UNL_RD;
                end else begin
                    state_next = ST_MERGE_RD;
                end
            end
            ST_MERGE_RD: begin
                rd_addr = PW'(buddy);
                if ((32'(cur_ord_reg) < ORDER_COUNT - 1) && (buddy < PC_E)) begin
                    state_next = ST_MERGE_EV;
                end else begin
                    state_next = ST_FREE_INS;
                end
            end
            ST_MERGE_EV: begin
                if (meta_rdata[META_W-1] && (u_ord == cur_ord_reg)) begin
                    unl_p_next   = PW'(buddy);
                    unl_ret_next = ST_MERGE_RD;
                    state_next   = ST_UNL_RD;
                    if (buddy < EW'(cur_reg)) begin
                        cur_next = CW'(buddy);
                    end
                    cur_ord_next = cur_ord_reg + ORDER_W'(1);
                end else begin
                    state_next = ST_FREE_INS;
                end
            end
            ST_FREE_INS: begin
                ins_p_next   = PW'(cur_reg);
                ins_o_next   = cur_ord_reg;
                ins_ret_next = ST_FINISH;
                state_next   = ST_INS_RD;
            end
            ST_INS_RD: begin
                rd_addr    = ins_p_reg;
                state_next = ST_INS_EV;
            end
            ST_INS_EV: begin
                // A head that is already free leaves its old list first.
                if (meta_rdata[META_W-1]) begin
                    unl_p_next   = ins_p_reg;
                    unl_ret_next = ST_INS_LINK;
                    state_next   = ST_UNL_RD;
                end else begin
                    state_next = ST_INS_LINK;
                end
            end
            ST_INS_LINK: begin
                h_next     = head_reg[ins_o_reg[OBW-1:0]];
                next_we    = 1'b1;
                next_wdata = head_reg[ins_o_reg[OBW-1:0]];
                prev_we    = 1'b1;
                prev_wdata = NO_LINK;
                meta_we    = 1'b1;
                meta_wdata = {1'b1, ins_o_reg};
                head_next[ins_o_reg[OBW-1:0]] = LW'(ins_p_reg);
                total_next = (add_sum > POW_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                           : TOTAL_W'(add_sum);
                state_next = ST_INS_PREV;
            end
            ST_INS_PREV: begin
                if (EW'(h_reg) < PC_E) begin
                    prev_we    = 1'b1;
                    prev_waddr = PW'(h_reg);
                    prev_wdata = LW'(ins_p_reg);
                end
                state_next = ins_ret_reg;
            end
            ST_UNL_RD: begin
                rd_addr    = unl_p_reg;
                state_next = ST_UNL_WR;
            end
            ST_UNL_WR: begin
                if (EW'(prev_rdata) < PC_E) begin
                    next_we    = 1'b1;
                    next_waddr = PW'(prev_rdata);
                    next_wdata = next_rdata;
                end else begin
                    head_next[u_idx] = (EW'(next_rdata) < PC_E) ? next_rdata : NO_LINK;
                end
                if (EW'(next_rdata) < PC_E) begin
                    prev_we    = 1'b1;
                    prev_waddr = PW'(next_rdata);
                    prev_wdata = prev_rdata;
                end
                meta_we    = 1'b1;
                meta_waddr = unl_p_reg;
                meta_wdata = '0;
                total_next = (POW_W'(total_reg) > u_pow)
                             ? TOTAL_W'(POW_W'(total_reg) - u_pow) : '0;
                state_next = unl_ret_reg;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_start_next  = start_reg;
                    out_total_next  = total_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < ORDER_COUNT; i++) begin
                head_reg[i] <= NO_LINK;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        ins_ret_reg    <= ins_ret_next;
        unl_ret_reg    <= unl_ret_next;
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        ord_reg        <= ord_next;
        cur_ord_reg    <= cur_ord_next;
        start_reg      <= start_next;
        status_reg     <= status_next;
        ins_p_reg      <= ins_p_next;
        ins_o_reg      <= ins_o_next;
        unl_p_reg      <= unl_p_next;
        h_reg          <= h_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_total_reg  <= out_total_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_total_reg, 12'(out_start_reg)};

endmodule
